/* design/rcr_pkg.sv */
// Shared constants, codes and types of the rectangle canvas rasterizer.
package rcr_pkg;

	// Defaults of the top-level parameters.
	localparam int DEF_MAX_WIDTH  = 512;
	localparam int DEF_MAX_HEIGHT = 512;
	localparam int DEF_FRAC_BITS  = 8;

	// Fixed field widths.
	localparam int KIND_W      = 2;
	localparam int COORD_W     = 24;
	localparam int BOUND_W     = 32;
	localparam int CHAR_W      = 8;
	localparam int CELL_IDX_W  = 9;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 10;
	localparam int DIM_W       = 10;

	// Item kinds.
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DRAW  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] CFG_CANVAS_WIDTH    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_CANVAS_HEIGHT   = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_BACKGROUND_CHAR = 2'd2;

	// Configuration reset values.
	localparam logic [DIM_W-1:0]  RST_CANVAS_WIDTH    = 10'd1;
	localparam logic [DIM_W-1:0]  RST_CANVAS_HEIGHT   = 10'd1;
	localparam logic [CHAR_W-1:0] RST_BACKGROUND_CHAR = 8'd32;

	// Result status codes.
	localparam logic STATUS_OK     = 1'b0;
	localparam logic STATUS_REJECT = 1'b1;

	// Command queue depth.
	localparam int QUEUE_DEPTH = 2;

	// Operations the back end carries out.
	typedef enum logic [1:0] {
		OP_CLEAR,
		OP_DRAW,
		OP_READ,
		OP_NONE
	} op_t;

	// Back end sequencer states.
	typedef enum logic [1:0] {
		B_IDLE,
		B_SWEEP,
		B_READ,
		B_RESP
	} back_state_t;

	// Classified command with precomputed rectangle bounds.
	typedef struct packed {
		op_t                        op;
		logic                       status;
		logic                       fill;
		logic [CHAR_W-1:0]          ch;
		logic signed [BOUND_W-1:0]  x0;
		logic signed [BOUND_W-1:0]  x1;
		logic signed [BOUND_W-1:0]  xr;
		logic signed [BOUND_W-1:0]  xr1;
		logic signed [BOUND_W-1:0]  y0;
		logic signed [BOUND_W-1:0]  y1;
		logic signed [BOUND_W-1:0]  yb;
		logic signed [BOUND_W-1:0]  yb1;
		logic [CELL_IDX_W-1:0]      row;
		logic [CELL_IDX_W-1:0]      col;
	} cmd_t;

endpackage

/* design/rcr_item_if.sv */
// Input item channel of the rectangle canvas rasterizer.
interface rcr_item_if;
	logic                                      valid;
	logic                                      ready;
	logic [rcr_pkg::KIND_W-1:0]                kind;
	logic                                      fill_mode;
	logic signed [rcr_pkg::COORD_W-1:0]        rect_left;
	logic signed [rcr_pkg::COORD_W-1:0]        rect_top;
	logic signed [rcr_pkg::COORD_W-1:0]        rect_width;
	logic signed [rcr_pkg::COORD_W-1:0]        rect_height;
	logic [rcr_pkg::CHAR_W-1:0]                draw_char;
	logic [rcr_pkg::CELL_IDX_W-1:0]            cell_row;
	logic [rcr_pkg::CELL_IDX_W-1:0]            cell_col;

	modport source (
		output valid, kind, fill_mode, rect_left, rect_top, rect_width, rect_height,
			draw_char, cell_row, cell_col,
		input  ready
	);
	modport sink (
		input  valid, kind, fill_mode, rect_left, rect_top, rect_width, rect_height,
			draw_char, cell_row, cell_col,
		output ready
	);
endinterface

/* design/rcr_result_if.sv */
// Result channel of the rectangle canvas rasterizer.
interface rcr_result_if;
	logic                        valid;
	logic                        ready;
	logic                        status;
	logic [rcr_pkg::CHAR_W-1:0]  cell_char;

	modport source (output valid, status, cell_char, input ready);
	modport sink (input valid, status, cell_char, output ready);
endinterface

/* design/rcr_cfg_if.sv */
// Configuration write channel of the rectangle canvas rasterizer.
interface rcr_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [rcr_pkg::CFG_INDEX_W-1:0]  index;
	logic [rcr_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* design/rcr_front.sv */
// Front end: takes input beats, classifies them and precomputes rectangle bounds.
module rcr_front #(
	parameter int FRAC_BITS = rcr_pkg::DEF_FRAC_BITS
) (
	input  logic            clk,
	input  logic            arst_n,
	rcr_item_if.sink        items,
	output logic            push_valid,
	input  logic            push_ready,
	output rcr_pkg::cmd_t   push_cmd
);

	localparam int BW = rcr_pkg::BOUND_W;

	logic                                   valid_s1;
	logic [rcr_pkg::KIND_W-1:0]             kind_s1;
	logic                                   fill_s1;
	logic signed [rcr_pkg::COORD_W-1:0]     left_s1;
	logic signed [rcr_pkg::COORD_W-1:0]     top_s1;
	logic signed [rcr_pkg::COORD_W-1:0]     width_s1;
	logic signed [rcr_pkg::COORD_W-1:0]     height_s1;
	logic [rcr_pkg::CHAR_W-1:0]             char_s1;
	logic [rcr_pkg::CELL_IDX_W-1:0]         row_s1;
	logic [rcr_pkg::CELL_IDX_W-1:0]         col_s1;

	logic signed [BW-1:0] one;
	logic signed [BW-1:0] x;
	logic signed [BW-1:0] y;
	logic signed [BW-1:0] w;
	logic signed [BW-1:0] h;

	// The stage frees up whenever its beat moves on to the queue.
	assign items.ready = !valid_s1 || push_ready;
	assign push_valid  = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.ready) begin
			valid_s1 <= items.valid;
		end
	end

	// Capture the accepted beat.
	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			kind_s1   <= items.kind;
			fill_s1   <= items.fill_mode;
			left_s1   <= items.rect_left;
			top_s1    <= items.rect_top;
			width_s1  <= items.rect_width;
			height_s1 <= items.rect_height;
			char_s1   <= items.draw_char;
			row_s1    <= items.cell_row;
			col_s1    <= items.cell_col;
		end
	end

	// Sign-extend the coordinates into the bound width.
	assign one = signed'(BW'(1) << FRAC_BITS);
	assign x   = BW'(left_s1);
	assign y   = BW'(top_s1);
	assign w   = BW'(width_s1);
	assign h   = BW'(height_s1);

	// Classify the item and form the edges that the sweep compares against.
	always_comb begin
		push_cmd        = '0;
		push_cmd.fill   = fill_s1;
		push_cmd.ch     = char_s1;
		push_cmd.row    = row_s1;
		push_cmd.col    = col_s1;
		push_cmd.status = rcr_pkg::STATUS_OK;
		push_cmd.x0     = x;
		push_cmd.x1     = x + one;
		push_cmd.xr     = x + w;
		push_cmd.xr1    = x + w - one;
		push_cmd.y0     = y;
		push_cmd.y1     = y + one;
		push_cmd.yb     = y + h;
		push_cmd.yb1    = y + h - one;
		case (kind_s1)
			rcr_pkg::KIND_CLEAR: begin
				push_cmd.op = rcr_pkg::OP_CLEAR;
			end
			rcr_pkg::KIND_DRAW: begin
				if (w <= 0 || h <= 0) begin
					push_cmd.op     = rcr_pkg::OP_NONE;
					push_cmd.status = rcr_pkg::STATUS_REJECT;
				end else begin
					push_cmd.op = rcr_pkg::OP_DRAW;
				end
			end
			rcr_pkg::KIND_READ: begin
				push_cmd.op = rcr_pkg::OP_READ;
			end
			default: begin
				push_cmd.op = rcr_pkg::OP_NONE;
			end
		endcase
	end

endmodule

/* design/rcr_queue.sv */
// Short command queue between the front end and the back end.
module rcr_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  rcr_pkg::cmd_t   push_cmd,
	output logic            pop_valid,
	input  logic            pop_ready,
	output rcr_pkg::cmd_t   pop_cmd
);

	localparam int DEPTH = rcr_pkg::QUEUE_DEPTH;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW  = $clog2(DEPTH + 1);

	rcr_pkg::cmd_t    entry_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CNTW-1:0]  count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNTW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNTW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNTW'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

/* design/rcr_back.sv */
// Back end: owns the canvas memory, sweeps clears and draws, answers reads.
module rcr_back #(
	parameter int MAX_WIDTH  = rcr_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = rcr_pkg::DEF_MAX_HEIGHT,
	parameter int FRAC_BITS  = rcr_pkg::DEF_FRAC_BITS,
	localparam int CW        = $clog2(MAX_WIDTH + 1),
	localparam int RW        = $clog2(MAX_HEIGHT + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         pop_valid,
	output logic                         pop_ready,
	input  rcr_pkg::cmd_t                pop_cmd,
	input  logic [CW-1:0]                cols,
	input  logic [RW-1:0]                rows,
	input  logic [rcr_pkg::CHAR_W-1:0]   background,
	rcr_result_if.source                 results
);

	localparam int CB    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int RB    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int AW    = RB + CB;
	localparam int DEPTH = 1 << AW;
	localparam int BW    = rcr_pkg::BOUND_W;

	rcr_pkg::back_state_t         state_q;
	rcr_pkg::back_state_t         state_d;
	rcr_pkg::cmd_t                cmd_q;
	logic [RB-1:0]                r_q;
	logic [CB-1:0]                c_q;
	logic                         res_valid_q;
	logic                         res_status_q;
	logic [rcr_pkg::CHAR_W-1:0]   res_char_q;
	logic [rcr_pkg::CHAR_W-1:0]   rd_data_q;
	logic [rcr_pkg::CHAR_W-1:0]   mem [DEPTH];

	logic                         load_cmd;
	logic                         step;
	logic                         load_res;
	logic                         canvas_empty;
	logic                         last_col;
	logic                         last_row;
	logic signed [BW-1:0]         fi;
	logic signed [BW-1:0]         fj;
	logic                         row_in;
	logic                         col_in;
	logic                         on_edge;
	logic                         wr_en;
	logic [rcr_pkg::CHAR_W-1:0]   wr_data;
	logic [31:0]                  rd_row_ext;
	logic [31:0]                  rd_col_ext;
	logic [AW-1:0]                rd_addr;
	logic                         rd_in_range;

	assign canvas_empty = (rows == '0) || (cols == '0);
	assign last_col     = (CW'(c_q) + CW'(1) == cols);
	assign last_row     = (RW'(r_q) + RW'(1) == rows);
	assign pop_ready    = (state_q == rcr_pkg::B_IDLE);

	// Sequencer: pop a command, sweep or read, then post the result.
	always_comb begin
		state_d  = state_q;
		load_cmd = 1'b0;
		step     = 1'b0;
		load_res = 1'b0;
		case (state_q)
			rcr_pkg::B_IDLE: begin
				if (pop_valid) begin
					load_cmd = 1'b1;
					case (pop_cmd.op)
						rcr_pkg::OP_CLEAR, rcr_pkg::OP_DRAW: begin
							state_d = canvas_empty ? rcr_pkg::B_RESP : rcr_pkg::B_SWEEP;
						end
						rcr_pkg::OP_READ: begin
							state_d = rcr_pkg::B_READ;
						end
						default: begin
							state_d = rcr_pkg::B_RESP;
						end
					endcase
				end
			end
			rcr_pkg::B_SWEEP: begin
				step = 1'b1;
				if (last_col && last_row) begin
					state_d = rcr_pkg::B_RESP;
				end
			end
			rcr_pkg::B_READ: begin
				state_d = rcr_pkg::B_RESP;
			end
			rcr_pkg::B_RESP: begin
				if (!res_valid_q || results.ready) begin
					load_res = 1'b1;
					state_d  = rcr_pkg::B_IDLE;
				end
			end
			default: begin
				state_d = rcr_pkg::B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rcr_pkg::B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Row and column counters of the sweep, row-major order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q <= '0;
			c_q <= '0;
		end else if (load_cmd) begin
			r_q <= '0;
			c_q <= '0;
		end else if (step) begin
			if (last_col) begin
				c_q <= '0;
				r_q <= r_q + RB'(1);
			end else begin
				c_q <= c_q + CB'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_cmd) begin
			cmd_q <= pop_cmd;
		end
	end

	// Coverage test of the current cell against the precomputed edges.
	assign fi      = signed'(BW'(r_q) << FRAC_BITS);
	assign fj      = signed'(BW'(c_q) << FRAC_BITS);
	assign row_in  = (fi >= cmd_q.y0) && (fi <= cmd_q.yb);
	assign col_in  = (fj >= cmd_q.x0) && (fj <= cmd_q.xr);
	assign on_edge = (fi < cmd_q.y1) || (fi > cmd_q.yb1) ||
		(fj < cmd_q.x1) || (fj > cmd_q.xr1);

	always_comb begin
		if (cmd_q.op == rcr_pkg::OP_CLEAR) begin
			wr_en   = step;
			wr_data = background;
		end else begin
			wr_en   = step && (cmd_q.op == rcr_pkg::OP_DRAW) && row_in && col_in &&
				(cmd_q.fill || on_edge);
			wr_data = cmd_q.ch;
		end
	end

	// Read address and range check of a read command.
	assign rd_row_ext  = 32'(cmd_q.row);
	assign rd_col_ext  = 32'(cmd_q.col);
	assign rd_addr     = {rd_row_ext[RB-1:0], rd_col_ext[CB-1:0]};
	assign rd_in_range = (rd_row_ext < 32'(rows)) && (rd_col_ext < 32'(cols));

	// Canvas memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[{r_q, c_q}] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	// Output register; it holds a finished result until its beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_res) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			res_status_q <= cmd_q.status;
			res_char_q   <= (cmd_q.op == rcr_pkg::OP_READ && rd_in_range) ? rd_data_q : '0;
		end
	end

	assign results.valid     = res_valid_q;
	assign results.status    = res_status_q;
	assign results.cell_char = res_char_q;

endmodule

/* design/rectangle_canvas_rasterizer_top.sv */
// Top level of the rectangle canvas rasterizer: configuration, front, queue, back.
//
//  channel   modport  beat carries
//  items     sink     kind, fill_mode, rect_left/top/width/height, draw_char, cell_row/col
//  results   source   status, cell_char
//  cfg       sink     index, data (always ready)
//
// A clear or draw over a nonempty canvas sweeps every cell in the sweep state before its
// result beat; a read passes through the read state, and a rejected draw, an unused kind or a
// clear or draw over an empty canvas goes from idle straight to the result state.
// The sweep writes one canvas cell per cycle through the single memory write port.
// Reset leaves the canvas contents undefined; a clear must cover a cell before it is read.
// The front stage and a two-entry queue keep taking items while the back end works or
// while a result waits in the output register.
module rectangle_canvas_rasterizer_top #(
	parameter int MAX_WIDTH  = rcr_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = rcr_pkg::DEF_MAX_HEIGHT,
	parameter int FRAC_BITS  = rcr_pkg::DEF_FRAC_BITS
) (
	input  logic           clk,
	input  logic           arst_n,
	rcr_item_if.sink       items,
	rcr_result_if.source   results,
	rcr_cfg_if.sink        cfg
);

	localparam int CW = $clog2(MAX_WIDTH + 1);
	localparam int RW = $clog2(MAX_HEIGHT + 1);

	logic [rcr_pkg::DIM_W-1:0]    canvas_width_q;
	logic [rcr_pkg::DIM_W-1:0]    canvas_height_q;
	logic [rcr_pkg::CHAR_W-1:0]   background_char_q;
	logic [CW-1:0]                cols;
	logic [RW-1:0]                rows;

	logic                         push_valid;
	logic                         push_ready;
	rcr_pkg::cmd_t                push_cmd;
	logic                         pop_valid;
	logic                         pop_ready;
	rcr_pkg::cmd_t                pop_cmd;

	// Configuration registers.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			canvas_width_q    <= rcr_pkg::RST_CANVAS_WIDTH;
			canvas_height_q   <= rcr_pkg::RST_CANVAS_HEIGHT;
			background_char_q <= rcr_pkg::RST_BACKGROUND_CHAR;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				rcr_pkg::CFG_CANVAS_WIDTH: begin
					canvas_width_q <= cfg.data[rcr_pkg::DIM_W-1:0];
				end
				rcr_pkg::CFG_CANVAS_HEIGHT: begin
					canvas_height_q <= cfg.data[rcr_pkg::DIM_W-1:0];
				end
				rcr_pkg::CFG_BACKGROUND_CHAR: begin
					background_char_q <= cfg.data[rcr_pkg::CHAR_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Canvas size in use, limited to the memory dimensions.
	assign cols = (32'(canvas_width_q) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(canvas_width_q);
	assign rows = (32'(canvas_height_q) > MAX_HEIGHT) ? RW'(MAX_HEIGHT) : RW'(canvas_height_q);

	rcr_front #(
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.items      (items),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	rcr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	rcr_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.FRAC_BITS  (FRAC_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd),
		.cols       (cols),
		.rows       (rows),
		.background (background_char_q),
		.results    (results)
	);

endmodule

/* dv/tb_top.sv */
// Testbench of the rectangle canvas rasterizer, checked against a canvas predictor.
module tb_top;
	import rcr_pkg::*;

	localparam int MAX_W     = DEF_MAX_WIDTH;
	localparam int MAX_H     = DEF_MAX_HEIGHT;
	localparam int CELLS     = MAX_W * MAX_H;
	localparam int ONE_UNIT  = 1 << DEF_FRAC_BITS;
	localparam int COORD_MIN = -8388608;
	localparam int COORD_MAX = 8388607;
	localparam logic [KIND_W-1:0]      KIND_UNUSED = 2'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED  = 2'd3;
	// The slowest correct run ends well within this limit.
	localparam longint LIMIT_CYCLES = 4000000;

	typedef struct {
		logic [KIND_W-1:0]          kind;
		logic                       fill;
		logic signed [COORD_W-1:0]  left;
		logic signed [COORD_W-1:0]  top;
		logic signed [COORD_W-1:0]  wid;
		logic signed [COORD_W-1:0]  hgt;
		logic [CHAR_W-1:0]          ch;
		logic [CELL_IDX_W-1:0]      row;
		logic [CELL_IDX_W-1:0]      col;
	} canvas_cmd_t;

	typedef struct {
		logic               status;
		logic [CHAR_W-1:0]  cell_char;
	} canvas_resp_t;

	logic clk;
	logic arst_n;
	bit   idle_on = 1'b1;
	int   mismatch_count = 0;

	// Predicted canvas contents, cells covered by a clear, and register copies.
	bit [CHAR_W-1:0] canvas_mem [0:CELLS-1];
	bit              cleared_map [0:CELLS-1];
	int unsigned     canvas_cols_reg = RST_CANVAS_WIDTH;
	int unsigned     canvas_rows_reg = RST_CANVAS_HEIGHT;
	bit [CHAR_W-1:0] bg_char_reg     = RST_BACKGROUND_CHAR;

	canvas_resp_t pending_resp [$];

	rcr_item_if   items_if ();
	rcr_result_if results_if ();
	rcr_cfg_if    cfg_if ();

	rectangle_canvas_rasterizer_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items_if),
		.results (results_if),
		.cfg     (cfg_if)
	);

	// Clock; the single reset pulse is driven by the main sequence.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Run limit.
	initial begin
		#(LIMIT_CYCLES * 4);
		$display("FAIL");
		$finish;
	end

	function automatic int unsigned cols_used();
		return (canvas_cols_reg > MAX_W) ? MAX_W : canvas_cols_reg;
	endfunction

	function automatic int unsigned rows_used();
		return (canvas_rows_reg > MAX_H) ? MAX_H : canvas_rows_reg;
	endfunction

	// A read is allowed outside the canvas in use or on a cell that a clear covered.
	function automatic bit cell_readable(int unsigned r, int unsigned c);
		if (r >= rows_used() || c >= cols_used())
			return 1'b1;
		return cleared_map[r * MAX_W + c];
	endfunction

	// Applies one command to the predicted canvas and returns its result.
	function automatic canvas_resp_t canvas_apply(canvas_cmd_t c);
		canvas_resp_t rsp;
		int unsigned  rows;
		int unsigned  cols;
		int unsigned  r;
		int unsigned  k;
		longint       x;
		longint       y;
		longint       w;
		longint       h;
		longint       fi;
		longint       fj;
		bit           border;
		rsp.status = STATUS_OK;
		rsp.cell_char = '0;
		rows = rows_used();
		cols = cols_used();
		case (c.kind)
			KIND_CLEAR: begin
				for (r = 0; r < rows; r++)
					for (k = 0; k < cols; k++) begin
						canvas_mem[r * MAX_W + k] = bg_char_reg;
						cleared_map[r * MAX_W + k] = 1'b1;
					end
			end
			KIND_DRAW: begin
				x = c.left;
				y = c.top;
				w = c.wid;
				h = c.hgt;
				if (w <= 0 || h <= 0) begin
					rsp.status = STATUS_REJECT;
				end else begin
					for (r = 0; r < rows; r++) begin
						fi = longint'(r) * ONE_UNIT;
						if (fi < y || fi > y + h)
							continue;
						for (k = 0; k < cols; k++) begin
							fj = longint'(k) * ONE_UNIT;
							if (fj < x || fj > x + w)
								continue;
							border = (fi - y < ONE_UNIT) || (y + h - fi < ONE_UNIT) ||
								(fj - x < ONE_UNIT) || (x + w - fj < ONE_UNIT);
							if (c.fill || border)
								canvas_mem[r * MAX_W + k] = c.ch;
						end
					end
				end
			end
			KIND_READ: begin
				if (c.row < rows && c.col < cols)
					rsp.cell_char = canvas_mem[c.row * MAX_W + c.col];
			end
			default: begin
			end
		endcase
		return rsp;
	endfunction

	function automatic canvas_cmd_t mk_cmd(logic [KIND_W-1:0] kind);
		canvas_cmd_t c;
		c.kind = kind;
		c.fill = 1'b0;
		c.left = '0;
		c.top  = '0;
		c.wid  = '0;
		c.hgt  = '0;
		c.ch   = '0;
		c.row  = '0;
		c.col  = '0;
		return c;
	endfunction

	function automatic canvas_cmd_t mk_draw(bit fill, int l, int t, int w, int h, int ch);
		canvas_cmd_t c;
		c = mk_cmd(KIND_DRAW);
		c.fill = fill;
		c.left = COORD_W'(l);
		c.top  = COORD_W'(t);
		c.wid  = COORD_W'(w);
		c.hgt  = COORD_W'(h);
		c.ch   = CHAR_W'(ch);
		return c;
	endfunction

	function automatic canvas_cmd_t mk_read(int r, int c);
		canvas_cmd_t cmd;
		cmd = mk_cmd(KIND_READ);
		cmd.row = CELL_IDX_W'(r);
		cmd.col = CELL_IDX_W'(c);
		return cmd;
	endfunction

	// Fills every field of a command but its kind with random bits.
	function automatic canvas_cmd_t mk_noise(logic [KIND_W-1:0] kind);
		canvas_cmd_t c;
		c.kind = kind;
		c.fill = 1'($urandom());
		c.left = COORD_W'($urandom());
		c.top  = COORD_W'($urandom());
		c.wid  = COORD_W'($urandom());
		c.hgt  = COORD_W'($urandom());
		c.ch   = CHAR_W'($urandom());
		c.row  = CELL_IDX_W'($urandom());
		c.col  = CELL_IDX_W'($urandom());
		return c;
	endfunction

	// A rectangle that lands on or near the canvas in use, sometimes on whole units.
	function automatic canvas_cmd_t mk_rand_draw();
		int l;
		int t;
		int w;
		int h;
		int cols;
		int rows;
		cols = int'(cols_used());
		rows = int'(rows_used());
		l = int'($urandom_range(0, (cols + 4) * ONE_UNIT)) - 2 * ONE_UNIT;
		t = int'($urandom_range(0, (rows + 4) * ONE_UNIT)) - 2 * ONE_UNIT;
		w = int'($urandom_range(1, (cols + 2) * ONE_UNIT));
		h = int'($urandom_range(1, (rows + 2) * ONE_UNIT));
		if ($urandom_range(0, 3) == 0) begin
			l = l & ~(ONE_UNIT - 1);
			t = t & ~(ONE_UNIT - 1);
			w = (w & ~(ONE_UNIT - 1)) + ONE_UNIT;
			h = (h & ~(ONE_UNIT - 1)) + ONE_UNIT;
		end
		return mk_draw(1'($urandom()), l, t, w, h, int'($urandom_range(0, 255)));
	endfunction

	function automatic canvas_cmd_t mk_rand_read();
		int r;
		int c;
		do begin
			if ($urandom_range(0, 4) == 0) begin
				r = int'($urandom_range(0, 511));
				c = int'($urandom_range(0, 511));
			end else begin
				r = int'($urandom_range(0, rows_used() - 1));
				c = int'($urandom_range(0, cols_used() - 1));
			end
		end while (!cell_readable(r, c));
		return mk_read(r, c);
	endfunction

	// Sends one item beat and records the predicted result once it is accepted.
	task automatic push_item(canvas_cmd_t c);
		@(negedge clk);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			items_if.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		items_if.valid       <= 1'b1;
		items_if.kind        <= c.kind;
		items_if.fill_mode   <= c.fill;
		items_if.rect_left   <= c.left;
		items_if.rect_top    <= c.top;
		items_if.rect_width  <= c.wid;
		items_if.rect_height <= c.hgt;
		items_if.draw_char   <= c.ch;
		items_if.cell_row    <= c.row;
		items_if.cell_col    <= c.col;
		do @(posedge clk); while (!items_if.ready);
		pending_resp.push_back(canvas_apply(c));
	endtask

	// Stops sending and waits until every predicted result has come back.
	task automatic drain_results();
		@(negedge clk);
		items_if.valid <= 1'b0;
		while (pending_resp.size() != 0)
			@(posedge clk);
	endtask

	// Writes one configuration register; only called while the block is idle.
	task automatic write_reg(logic [CFG_INDEX_W-1:0] index, int data);
		logic [CFG_DATA_W-1:0] value;
		value = CFG_DATA_W'(data);
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= index;
		cfg_if.data  <= value;
		do @(posedge clk); while (!cfg_if.ready);
		case (index)
			CFG_CANVAS_WIDTH:    canvas_cols_reg = value;
			CFG_CANVAS_HEIGHT:   canvas_rows_reg = value;
			CFG_BACKGROUND_CHAR: bg_char_reg = value[CHAR_W-1:0];
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	task automatic set_canvas(int cols, int rows, int bg);
		drain_results();
		write_reg(CFG_CANVAS_WIDTH, cols);
		write_reg(CFG_CANVAS_HEIGHT, rows);
		write_reg(CFG_BACKGROUND_CHAR, bg);
	endtask

	// One-cell canvas after reset: outside read, clear, inside read.
	task automatic test_reset_canvas();
		push_item(mk_read(1, 0));
		push_item(mk_cmd(KIND_CLEAR));
		push_item(mk_read(0, 0));
	endtask

	// Filled and outlined rectangles with fractional corners; unused register index.
	task automatic test_fill_and_outline();
		set_canvas(10, 8, 'h3A5);
		write_reg(CFG_UNUSED, 'h3FF);
		push_item(mk_cmd(KIND_CLEAR));
		push_item(mk_draw(1'b1, 384, 256, 1088, 768, "R"));
		push_item(mk_draw(1'b0, 128, 192, 1536, 1408, "r"));
		push_item(mk_read(3, 4));
		push_item(mk_read(7, 9));
		push_item(mk_read(8, 10));
	endtask

	// Sizes that are zero or negative are answered with a reject status; an item of an unused kind is also sent.
	task automatic test_rejected_draw();
		push_item(mk_draw(1'b1, 0, 0, 0, ONE_UNIT, 'hFF));
		push_item(mk_draw(1'b0, 0, 0, ONE_UNIT, COORD_MIN, 'hFF));
		push_item(mk_noise(KIND_UNUSED));
	endtask

	// Coordinates and sizes at the limits of the signed fields.
	task automatic test_extreme_coords();
		push_item(mk_draw(1'b1, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 'hFF));
		push_item(mk_draw(1'b0, COORD_MAX, COORD_MAX, 1, 1, 'h01));
		push_item(mk_draw(1'b1, -3 * ONE_UNIT, -3 * ONE_UNIT, COORD_MAX, COORD_MAX, 'h80));
	endtask

	// A zero width leaves an empty canvas: nothing is cleared or drawn.
	task automatic test_empty_canvas();
		set_canvas(0, 8, 'h00);
		push_item(mk_cmd(KIND_CLEAR));
		push_item(mk_draw(1'b1, 0, 0, ONE_UNIT, ONE_UNIT, "X"));
		push_item(mk_read(0, 0));
	endtask

	// Register values above the maximum saturate to the full size.
	task automatic test_oversized_canvas();
		set_canvas('h3FF, 2, 'h000);
		push_item(mk_cmd(KIND_CLEAR));
		push_item(mk_draw(1'b0, 500 * ONE_UNIT, 0, 11 * ONE_UNIT, ONE_UNIT, "r"));
		push_item(mk_read(1, 511));
		set_canvas(2, 'h3FF, 'h3C3);
		push_item(mk_cmd(KIND_CLEAR));
		push_item(mk_read(511, 1));
	endtask

	// The largest canvas, swept once by a clear and once by an outline.
	task automatic test_full_canvas();
		set_canvas(MAX_W, MAX_H, "." );
		push_item(mk_cmd(KIND_CLEAR));
		push_item(mk_draw(1'b0, 0, 0, 511 * ONE_UNIT, 511 * ONE_UNIT, "r"));
		push_item(mk_read(511, 511));
		push_item(mk_read(255, 256));
	endtask

	// Mostly well-formed rectangles and reads, with some noise and broken sizes.
	task automatic random_phase(int count);
		int pick;
		canvas_cmd_t c;
		set_canvas($urandom_range(1, 20), $urandom_range(1, 20), $urandom_range(0, 1023));
		push_item(mk_noise(KIND_CLEAR));
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				c = mk_rand_draw();
			end else if (pick < 55) begin
				c = mk_noise(KIND_DRAW);
			end else if (pick < 60) begin
				c = mk_rand_draw();
				c.wid = COORD_W'(-int'($urandom_range(0, 2000)));
			end else if (pick < 90) begin
				c = mk_rand_read();
			end else if (pick < 95) begin
				c = mk_noise(KIND_CLEAR);
			end else begin
				c = mk_noise(KIND_UNUSED);
			end
			push_item(c);
		end
	endtask

	task automatic test_random_traffic();
		repeat (4) random_phase(15);
	endtask

	// Final stretch with no idling on either side.
	task automatic test_back_to_back();
		drain_results();
		idle_on = 1'b0;
		random_phase(15);
	endtask

	// Result beat readiness with random stall bursts.
	initial begin : result_ready_drv
		int stall;
		results_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 7) == 0) begin
				stall = $urandom_range(1, 15);
				results_if.ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end else begin
				results_if.ready <= 1'b1;
			end
		end
	end

	// Compares every accepted result beat with the oldest prediction.
	always @(posedge clk) begin : check_resp
		canvas_resp_t want;
		if (arst_n && results_if.valid && results_if.ready) begin
			if (pending_resp.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual status %0d cell_char %0d",
					$time, results_if.status, results_if.cell_char);
				mismatch_count++;
			end else begin
				want = pending_resp.pop_front();
				if (results_if.status !== want.status) begin
					$display("%0t: status mismatch, expected %0d, actual %0d",
						$time, want.status, results_if.status);
					mismatch_count++;
				end
				if (results_if.cell_char !== want.cell_char) begin
					$display("%0t: cell_char mismatch, expected %0d, actual %0d",
						$time, want.cell_char, results_if.cell_char);
					mismatch_count++;
				end
			end
		end
	end

	// Main sequence.
	initial begin
		arst_n = 1'b0;
		items_if.valid = 1'b0;
		items_if.kind = KIND_CLEAR;
		items_if.fill_mode = 1'b0;
		items_if.rect_left = '0;
		items_if.rect_top = '0;
		items_if.rect_width = '0;
		items_if.rect_height = '0;
		items_if.draw_char = '0;
		items_if.cell_row = '0;
		items_if.cell_col = '0;
		cfg_if.valid = 1'b0;
		cfg_if.index = CFG_CANVAS_WIDTH;
		cfg_if.data = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		test_reset_canvas();
		test_fill_and_outline();
		test_rejected_draw();
		test_extreme_coords();
		test_empty_canvas();
		test_oversized_canvas();
		test_full_canvas();
		test_random_traffic();
		test_back_to_back();

		drain_results();
		repeat (16) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
